>>> rtl/hkbd_pkg.sv
// ----------------------------------------------------------------------------
// hkbd_pkg
// Shared constants, types and the usage-to-key map for the boot-keyboard
// report decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hkbd_pkg;

   localparam int HKBD_MAX_HELD = 8;

   localparam int KEY_W       = 6;
   localparam int USAGE_W     = 8;
   localparam int MOD_W       = 8;
   localparam int N_USAGE     = 6;
   localparam int USAGE_IDX_W = 3;

   localparam int MOD_SHIFT_BIT = 1;
   localparam int MOD_ALT_BIT   = 2;

   // key codes
   localparam logic [KEY_W-1:0] KEY_DIGIT0 = 6'd26;
   localparam logic [KEY_W-1:0] KEY_DIGIT1 = 6'd27;
   localparam logic [KEY_W-1:0] KEY_ENTER  = 6'd36;
   localparam logic [KEY_W-1:0] KEY_SPACE  = 6'd37;
   localparam logic [KEY_W-1:0] KEY_SHIFT  = 6'd38;
   localparam logic [KEY_W-1:0] KEY_SYMB   = 6'd39;
   localparam logic [KEY_W-1:0] KEY_DEL    = 6'd40;

   // HID usage codes
   localparam logic [USAGE_W-1:0] USAGE_A         = 8'h04;
   localparam logic [USAGE_W-1:0] USAGE_Z         = 8'h1D;
   localparam logic [USAGE_W-1:0] USAGE_1         = 8'h1E;
   localparam logic [USAGE_W-1:0] USAGE_9         = 8'h26;
   localparam logic [USAGE_W-1:0] USAGE_0         = 8'h27;
   localparam logic [USAGE_W-1:0] USAGE_ENTER     = 8'h28;
   localparam logic [USAGE_W-1:0] USAGE_BACKSPACE = 8'h2A;
   localparam logic [USAGE_W-1:0] USAGE_SPACE     = 8'h2C;

   // event kinds
   localparam logic EV_LEVEL  = 1'b0;
   localparam logic EV_NOTIFY = 1'b1;

   localparam logic ACTION_REPORT     = 1'b0;
   localparam logic ACTION_DISCONNECT = 1'b1;

   typedef struct packed {
      logic             hit;
      logic [KEY_W-1:0] key;
   } hkbd_map_type;

   typedef struct packed {
      logic wr_en;
      logic swap;
   } hkbd_store_ctl_type;

   function automatic hkbd_map_type hkbd_map_usage(input logic [USAGE_W-1:0] u);
      hkbd_map_type m;
      logic [USAGE_W-1:0] d;
      m.hit = 1'b0;
      m.key = '0;
      d     = '0;
      if (u inside {[USAGE_A:USAGE_Z]}) begin
         d     = u - USAGE_A;
         m.hit = 1'b1;
         m.key = d[KEY_W-1:0];
      end else if (u inside {[USAGE_1:USAGE_9]}) begin
         d     = u - USAGE_1;
         m.hit = 1'b1;
         m.key = KEY_DIGIT1 + d[KEY_W-1:0];
      end else if (u == USAGE_0) begin
         m.hit = 1'b1;
         m.key = KEY_DIGIT0;
      end else if (u == USAGE_ENTER) begin
         m.hit = 1'b1;
         m.key = KEY_ENTER;
      end else if (u == USAGE_SPACE) begin
         m.hit = 1'b1;
         m.key = KEY_SPACE;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

>>> rtl/hkbd_key_store.sv
// ----------------------------------------------------------------------------
// hkbd_key_store
// Two banks of key lists: one holds the keys held after the last report,
// the other is filled with the keys of the report in progress. A swap
// makes the new list the held one.
// ----------------------------------------------------------------------------
`default_nettype none

module hkbd_key_store #(
   parameter int MAX_HELD = hkbd_pkg::HKBD_MAX_HELD
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire hkbd_pkg::hkbd_store_ctl_type      ctl,
   input  wire logic [$clog2(MAX_HELD)-1:0]       wr_addr,
   input  wire logic [hkbd_pkg::KEY_W-1:0]        wr_key,
   input  wire logic [$clog2(MAX_HELD)-1:0]       held_addr,
   input  wire logic [$clog2(MAX_HELD)-1:0]       act_addr,
   output logic      [hkbd_pkg::KEY_W-1:0]        held_key,
   output logic      [hkbd_pkg::KEY_W-1:0]        act_key
);
   import hkbd_pkg::*;

   logic [KEY_W-1:0] bank_ff [2][MAX_HELD];
   logic             sel_ff;
   logic             sel_in;

   assign sel_in = ctl.swap ? ~sel_ff : sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   // the bank being built is the one not selected as held
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         bank_ff[~sel_ff][wr_addr] <= wr_key;
      end
   end

   assign held_key = bank_ff[sel_ff][held_addr];
   assign act_key  = bank_ff[~sel_ff][act_addr];

endmodule

`default_nettype wire

>>> rtl/hid_keyboard_report_to_key_events_core.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_key_events_core
// Decodes boot-keyboard reports into serialized key level and press events.
// ----------------------------------------------------------------------------
// Each event waits in a one-entry slot until the next one shows whether it is the
//   last; a disconnect emits no events and only clears the held list and latch.
// Reports are taken one at a time, as req_ready is high only in idle; the single key
//   comparator scans the held and new key lists one entry per cycle (a report
//   never holds more than 7 keys), and output stalls hold the emit states.
// Reset: synchronous; clears held count, backspace latch and all handshakes.
`default_nettype none

module hid_keyboard_report_to_key_events_core #(
   parameter int MAX_HELD = hkbd_pkg::HKBD_MAX_HELD
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_action,
   input  wire logic [hkbd_pkg::MOD_W-1:0]       req_modifiers,
   input  wire logic [hkbd_pkg::USAGE_W-1:0]     req_usage_0,
   input  wire logic [hkbd_pkg::USAGE_W-1:0]     req_usage_1,
   input  wire logic [hkbd_pkg::USAGE_W-1:0]     req_usage_2,
   input  wire logic [hkbd_pkg::USAGE_W-1:0]     req_usage_3,
   input  wire logic [hkbd_pkg::USAGE_W-1:0]     req_usage_4,
   input  wire logic [hkbd_pkg::USAGE_W-1:0]     req_usage_5,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_event_kind,
   output logic      [hkbd_pkg::KEY_W-1:0]       rsp_key,
   output logic                                  rsp_pressed,
   output logic                                  rsp_last
);
   import hkbd_pkg::*;

   localparam int IDX_W = $clog2(MAX_HELD);
   localparam int CNT_W = $clog2(MAX_HELD + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_HELD);
   localparam logic [USAGE_IDX_W-1:0] LAST_SLOT = USAGE_IDX_W'(N_USAGE - 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_SH_LVL, ST_SH_NTF, ST_AL_LVL, ST_AL_NTF,
      ST_MAP, ST_ADD,
      ST_REL_HEAD, ST_REL_SCAN, ST_REL_EMIT,
      ST_PRS_HEAD, ST_PRS_SCAN, ST_PRS_LVL, ST_PRS_NTF,
      ST_TAIL_SH, ST_TAIL_AL, ST_TAIL_DEL, ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [USAGE_W-1:0]   usage_ff [N_USAGE];
   logic [USAGE_W-1:0]   usage_in [N_USAGE];
   logic [USAGE_IDX_W-1:0] uidx_ff, uidx_in;
   logic                 shift_ff, shift_in;
   logic                 alt_ff, alt_in;
   logic                 bs_ff, bs_in;
   logic                 latch_ff, latch_in;
   logic [KEY_W-1:0]     cand_ff, cand_in;
   logic                 cand2_ff, cand2_in;
   logic [CNT_W-1:0]     nact_ff, nact_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     j_ff, j_in;

   // pending event waits until the next one shows whether it is the last
   logic                 pend_valid_ff, pend_valid_in;
   logic                 pend_kind_ff, pend_kind_in;
   logic [KEY_W-1:0]     pend_key_ff, pend_key_in;
   logic                 pend_pressed_ff, pend_pressed_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic                 rsp_pressed_ff, rsp_pressed_in;
   logic                 rsp_last_ff, rsp_last_in;

   hkbd_store_ctl_type   st_ctl;
   logic [IDX_W-1:0]     held_addr, act_addr;
   logic [KEY_W-1:0]     held_key, act_key;
   logic [KEY_W-1:0]     cmp_b;
   logic                 hit;
   logic                 out_free, can_push, push_req, push_fire;
   logic                 push_kind, push_pressed;
   logic [KEY_W-1:0]     push_key;
   logic                 flush_fire;
   hkbd_map_type         map_res;
   logic [USAGE_W-1:0]   cur_usage;

   hkbd_key_store #(
      .MAX_HELD (MAX_HELD)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (st_ctl),
      .wr_addr   (nact_ff[IDX_W-1:0]),
      .wr_key    (cand_ff),
      .held_addr (held_addr),
      .act_addr  (act_addr),
      .held_key  (held_key),
      .act_key   (act_key)
   );

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_key        = rsp_key_ff;
   assign rsp_pressed    = rsp_pressed_ff;
   assign rsp_last       = rsp_last_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign can_push  = !pend_valid_ff || out_free;
   assign cur_usage = usage_ff[uidx_ff];
   assign map_res   = hkbd_map_usage(cur_usage);

   // shared key comparator
   assign cmp_b = (state_ff == ST_ADD) ? cand_ff : held_key;
   assign hit   = (act_key == cmp_b);

   always_comb begin
      state_in = state_ff;
      usage_in = usage_ff;
      uidx_in  = uidx_ff;
      shift_in = shift_ff;
      alt_in   = alt_ff;
      bs_in    = bs_ff;
      latch_in = latch_ff;
      cand_in  = cand_ff;
      cand2_in = cand2_ff;
      nact_in  = nact_ff;
      count_in = count_ff;
      i_in     = i_ff;
      j_in     = j_ff;

      st_ctl       = '0;
      held_addr    = '0;
      act_addr     = '0;
      push_req     = 1'b0;
      push_kind    = EV_LEVEL;
      push_key     = '0;
      push_pressed = 1'b0;
      flush_fire   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACTION_DISCONNECT) begin
                  count_in = '0;
                  latch_in = 1'b0;
               end else begin
                  shift_in    = req_modifiers[MOD_SHIFT_BIT];
                  alt_in      = req_modifiers[MOD_ALT_BIT];
                  usage_in[0] = req_usage_0;
                  usage_in[1] = req_usage_1;
                  usage_in[2] = req_usage_2;
                  usage_in[3] = req_usage_3;
                  usage_in[4] = req_usage_4;
                  usage_in[5] = req_usage_5;
                  bs_in       = 1'b0;
                  nact_in     = '0;
                  uidx_in     = '0;
                  state_in    = ST_SH_LVL;
               end
            end
         end
         ST_SH_LVL, ST_SH_NTF: begin
            push_req     = shift_ff;
            push_kind    = (state_ff == ST_SH_NTF) ? EV_NOTIFY : EV_LEVEL;
            push_key     = KEY_SHIFT;
            push_pressed = 1'b1;
            if (!push_req || can_push) begin
               state_in = (state_ff == ST_SH_LVL) ? ST_SH_NTF : ST_AL_LVL;
            end
         end
         ST_AL_LVL, ST_AL_NTF: begin
            push_req     = alt_ff;
            push_kind    = (state_ff == ST_AL_NTF) ? EV_NOTIFY : EV_LEVEL;
            push_key     = KEY_SYMB;
            push_pressed = 1'b1;
            if (!push_req || can_push) begin
               state_in = (state_ff == ST_AL_LVL) ? ST_AL_NTF : ST_MAP;
            end
         end
         ST_MAP: begin
            j_in = '0;
            if (cur_usage == USAGE_BACKSPACE) begin
               bs_in    = 1'b1;
               cand_in  = KEY_SHIFT;
               cand2_in = 1'b1;
               state_in = ST_ADD;
            end else if (map_res.hit) begin
               cand_in  = map_res.key;
               cand2_in = 1'b0;
               state_in = ST_ADD;
            end else if (uidx_ff == LAST_SLOT) begin
               i_in     = '0;
               state_in = ST_REL_HEAD;
            end else begin
               uidx_in = uidx_ff + 1'b1;
            end
         end
         ST_ADD: begin
            act_addr = j_ff[IDX_W-1:0];
            if (j_ff == nact_ff || hit) begin
               if (j_ff == nact_ff && nact_ff < CNT_MAX) begin
                  st_ctl.wr_en = 1'b1;
                  nact_in      = nact_ff + 1'b1;
               end
               j_in = '0;
               if (cand2_ff) begin
                  // backspace also holds digit 0
                  cand_in  = KEY_DIGIT0;
                  cand2_in = 1'b0;
               end else if (uidx_ff == LAST_SLOT) begin
                  i_in     = '0;
                  state_in = ST_REL_HEAD;
               end else begin
                  uidx_in  = uidx_ff + 1'b1;
                  state_in = ST_MAP;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_REL_HEAD: begin
            j_in = '0;
            if (i_ff == count_ff) begin
               i_in     = '0;
               state_in = ST_PRS_HEAD;
            end else begin
               state_in = ST_REL_SCAN;
            end
         end
         ST_REL_SCAN: begin
            held_addr = i_ff[IDX_W-1:0];
            act_addr  = j_ff[IDX_W-1:0];
            if (j_ff == nact_ff) begin
               state_in = ST_REL_EMIT;
            end else if (hit) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_REL_HEAD;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_REL_EMIT: begin
            held_addr    = i_ff[IDX_W-1:0];
            push_req     = 1'b1;
            push_kind    = EV_LEVEL;
            push_key     = held_key;
            push_pressed = 1'b0;
            if (can_push) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_REL_HEAD;
            end
         end
         ST_PRS_HEAD: begin
            j_in = '0;
            if (i_ff == nact_ff) begin
               state_in = ST_TAIL_SH;
            end else begin
               state_in = ST_PRS_SCAN;
            end
         end
         ST_PRS_SCAN: begin
            held_addr = j_ff[IDX_W-1:0];
            act_addr  = i_ff[IDX_W-1:0];
            if (j_ff == count_ff) begin
               state_in = ST_PRS_LVL;
            end else if (hit) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_PRS_HEAD;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_PRS_LVL, ST_PRS_NTF: begin
            act_addr     = i_ff[IDX_W-1:0];
            push_req     = 1'b1;
            push_kind    = (state_ff == ST_PRS_NTF) ? EV_NOTIFY : EV_LEVEL;
            push_key     = act_key;
            push_pressed = 1'b1;
            if (can_push) begin
               if (state_ff == ST_PRS_LVL) begin
                  state_in = ST_PRS_NTF;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_PRS_HEAD;
               end
            end
         end
         ST_TAIL_SH: begin
            push_req     = !shift_ff && !bs_ff;
            push_kind    = EV_LEVEL;
            push_key     = KEY_SHIFT;
            push_pressed = 1'b0;
            if (!push_req || can_push) begin
               state_in = ST_TAIL_AL;
            end
         end
         ST_TAIL_AL: begin
            push_req     = !alt_ff;
            push_kind    = EV_LEVEL;
            push_key     = KEY_SYMB;
            push_pressed = 1'b0;
            if (!push_req || can_push) begin
               state_in = ST_TAIL_DEL;
            end
         end
         ST_TAIL_DEL: begin
            // delete fires only on the report where backspace first shows up
            push_req     = bs_ff && !latch_ff;
            push_kind    = EV_NOTIFY;
            push_key     = KEY_DEL;
            push_pressed = 1'b1;
            if (!push_req || can_push) begin
               latch_in    = bs_ff;
               st_ctl.swap = 1'b1;
               count_in    = nact_ff;
               state_in    = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               flush_fire = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign push_fire = push_req && can_push;

   always_comb begin
      pend_valid_in   = pend_valid_ff;
      pend_kind_in    = pend_kind_ff;
      pend_key_in     = pend_key_ff;
      pend_pressed_in = pend_pressed_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_key_in      = rsp_key_ff;
      rsp_pressed_in  = rsp_pressed_ff;
      rsp_last_in     = rsp_last_ff;
      if ((push_fire && pend_valid_ff) || flush_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = pend_kind_ff;
         rsp_key_in     = pend_key_ff;
         rsp_pressed_in = pend_pressed_ff;
         rsp_last_in    = flush_fire;
      end
      if (push_fire) begin
         pend_valid_in   = 1'b1;
         pend_kind_in    = push_kind;
         pend_key_in     = push_key;
         pend_pressed_in = push_pressed;
      end else if (flush_fire) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         latch_ff      <= 1'b0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff        <= state_in;
         usage_ff        <= usage_in;
         uidx_ff         <= uidx_in;
         shift_ff        <= shift_in;
         alt_ff          <= alt_in;
         bs_ff           <= bs_in;
         latch_ff        <= latch_in;
         cand_ff         <= cand_in;
         cand2_ff        <= cand2_in;
         nact_ff         <= nact_in;
         count_ff        <= count_in;
         i_ff            <= i_in;
         j_ff            <= j_in;
         pend_valid_ff   <= pend_valid_in;
         pend_kind_ff    <= pend_kind_in;
         pend_key_ff     <= pend_key_in;
         pend_pressed_ff <= pend_pressed_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_kind_ff     <= rsp_kind_in;
         rsp_key_ff      <= rsp_key_in;
         rsp_pressed_ff  <= rsp_pressed_in;
         rsp_last_ff     <= rsp_last_in;
      end
   end

endmodule

`default_nettype wire

>>> verif/tb_hid_keyboard_report_to_key_events_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hid_keyboard_report_to_key_events_core
// Feeds boot-keyboard reports and disconnects into the decoder. A local model
// of the held-key list and backspace latch predicts the serialized key events.
// Every event is checked in order; both handshakes are throttled at random, then run freely.
// ----------------------------------------------------------------------------
module tb_hid_keyboard_report_to_key_events_core;
   import hkbd_pkg::*;

   localparam int CLK_HALF      = 6;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 300;

   typedef logic [KEY_W-1:0] key_code_type;

   typedef struct packed {
      logic                            action;
      logic [MOD_W-1:0]                modifiers;
      logic [N_USAGE-1:0][USAGE_W-1:0] usage;
   } report_type;

   typedef struct packed {
      logic         kind;
      key_code_type key;
      logic         pressed;
      logic         last;
   } key_event_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic                req_action    = 1'b0;
   logic [MOD_W-1:0]    req_modifiers = '0;
   logic [USAGE_W-1:0]  req_usage_0   = '0;
   logic [USAGE_W-1:0]  req_usage_1   = '0;
   logic [USAGE_W-1:0]  req_usage_2   = '0;
   logic [USAGE_W-1:0]  req_usage_3   = '0;
   logic [USAGE_W-1:0]  req_usage_4   = '0;
   logic [USAGE_W-1:0]  req_usage_5   = '0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic                rsp_event_kind;
   key_code_type        rsp_key;
   logic                rsp_pressed;
   logic                rsp_last;

   // model state
   key_code_type        held_keys [HKBD_MAX_HELD];
   int                  held_num = 0;
   logic                bs_latch = 1'b0;
   key_event_type       pending_events [$];

   // usages currently "typed" by the random keyboard
   logic [USAGE_W-1:0]  typed [N_USAGE] = '{default: '0};

   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  failures      = 0;
   int                  quiet_cycles  = 0;

   hid_keyboard_report_to_key_events_core #(
      .MAX_HELD(HKBD_MAX_HELD)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_modifiers  (req_modifiers),
      .req_usage_0    (req_usage_0),
      .req_usage_1    (req_usage_1),
      .req_usage_2    (req_usage_2),
      .req_usage_3    (req_usage_3),
      .req_usage_4    (req_usage_4),
      .req_usage_5    (req_usage_5),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_key        (rsp_key),
      .rsp_pressed    (rsp_pressed),
      .rsp_last       (rsp_last)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic bit usage_to_key(input logic [USAGE_W-1:0] u,
                                       output key_code_type k);
      k = '0;
      if (u inside {[USAGE_A:USAGE_Z]}) begin
         k = key_code_type'(u - USAGE_A);
      end else if (u inside {[USAGE_1:USAGE_9]}) begin
         k = KEY_DIGIT1 + key_code_type'(u - USAGE_1);
      end else if (u == USAGE_0) begin
         k = KEY_DIGIT0;
      end else if (u == USAGE_ENTER) begin
         k = KEY_ENTER;
      end else if (u == USAGE_SPACE) begin
         k = KEY_SPACE;
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit list_has(input key_code_type list [HKBD_MAX_HELD], input int n,
                                   input key_code_type k);
      for (int i = 0; i < n; i++)
         if (list[i] == k) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void push_event(input logic kind, input key_code_type k,
                                      input logic pressed);
      key_event_type ev;
      ev.kind    = kind;
      ev.key     = k;
      ev.pressed = pressed;
      ev.last    = 1'b0;
      pending_events.insert(pending_events.size(), ev);
   endfunction

   function automatic void push_press(input key_code_type k);
      push_event(EV_LEVEL, k, 1'b1);
      push_event(EV_NOTIFY, k, 1'b1);
   endfunction

   function automatic void predict_report(input report_type r);
      key_code_type  active [HKBD_MAX_HELD];
      key_code_type  cand [2];
      key_code_type  k;
      key_event_type ev;
      int            n_act;
      int            n_prev;
      int            n_cand;
      int            base;
      int            i;
      int            j;
      bit            shift_dn;
      bit            alt_dn;
      bit            bs_dn;
      n_act = 0;
      bs_dn = 1'b0;
      base  = pending_events.size();
      if (r.action == ACTION_DISCONNECT) begin
         held_num = 0;
         bs_latch = 1'b0;
         return;
      end
      shift_dn = r.modifiers[MOD_SHIFT_BIT];
      alt_dn   = r.modifiers[MOD_ALT_BIT];
      n_prev   = held_num;
      if (shift_dn) push_press(KEY_SHIFT);
      if (alt_dn) push_press(KEY_SYMB);

      // backspace stands for caps shift plus digit 0
      for (i = 0; i < N_USAGE; i++) begin
         n_cand = 0;
         if (r.usage[i] == USAGE_BACKSPACE) begin
            bs_dn   = 1'b1;
            cand[0] = KEY_SHIFT;
            cand[1] = KEY_DIGIT0;
            n_cand  = 2;
         end else if (usage_to_key(r.usage[i], k)) begin
            cand[0] = k;
            n_cand  = 1;
         end
         for (j = 0; j < n_cand; j++) begin
            if (n_act < HKBD_MAX_HELD && !list_has(active, n_act, cand[j])) begin
               active[n_act] = cand[j];
               n_act++;
            end
         end
      end

      for (i = 0; i < n_prev; i++)
         if (!list_has(active, n_act, held_keys[i]))
            push_event(EV_LEVEL, held_keys[i], 1'b0);
      for (i = 0; i < n_act; i++)
         if (!list_has(held_keys, n_prev, active[i]))
            push_press(active[i]);

      if (!shift_dn && !bs_dn) push_event(EV_LEVEL, KEY_SHIFT, 1'b0);
      if (!alt_dn) push_event(EV_LEVEL, KEY_SYMB, 1'b0);

      if (bs_dn && !bs_latch) begin
         push_event(EV_NOTIFY, KEY_DEL, 1'b1);
         bs_latch = 1'b1;
      end else if (!bs_dn) begin
         bs_latch = 1'b0;
      end

      for (i = 0; i < n_act; i++) held_keys[i] = active[i];
      held_num = n_act;

      if (pending_events.size() > base) begin
         ev      = pending_events[pending_events.size() - 1];
         ev.last = 1'b1;
         pending_events[pending_events.size() - 1] = ev;
      end
   endfunction

   // -------------------------------------------------------------- checking

   function automatic void check_field(input string name, input logic [KEY_W-1:0] want,
                                       input logic [KEY_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      report_type    seen;
      key_event_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen.action    = req_action;
            seen.modifiers = req_modifiers;
            seen.usage[0]  = req_usage_0;
            seen.usage[1]  = req_usage_1;
            seen.usage[2]  = req_usage_2;
            seen.usage[3]  = req_usage_3;
            seen.usage[4]  = req_usage_4;
            seen.usage[5]  = req_usage_5;
            predict_report(seen);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               $error("unexpected event: kind %0d key %0d pressed %0d last %0d",
                      rsp_event_kind, rsp_key, rsp_pressed, rsp_last);
               failures++;
            end else begin
               want = pending_events.pop_front();
               check_field("event_kind", KEY_W'(want.kind), KEY_W'(rsp_event_kind));
               check_field("key", want.key, rsp_key);
               check_field("pressed", KEY_W'(want.pressed), KEY_W'(rsp_pressed));
               check_field("last", KEY_W'(want.last), KEY_W'(rsp_last));
            end
         end
      end
   end

   // stall watchdog: cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[hid_keyboard_report_to_key_events_core] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // -------------------------------------------------------------- stimulus

   // called and returns at a falling edge; valid stays up for a following item
   task automatic send_report(input report_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= r.action;
      req_modifiers <= r.modifiers;
      req_usage_0   <= r.usage[0];
      req_usage_1   <= r.usage[1];
      req_usage_2   <= r.usage[2];
      req_usage_3   <= r.usage[3];
      req_usage_4   <= r.usage[4];
      req_usage_5   <= r.usage[5];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_events.size() != 0) @(negedge clock);
   endtask

   function automatic report_type keyboard_report(
      input logic [MOD_W-1:0] mods,
      input logic [USAGE_W-1:0] u0, input logic [USAGE_W-1:0] u1,
      input logic [USAGE_W-1:0] u2, input logic [USAGE_W-1:0] u3,
      input logic [USAGE_W-1:0] u4, input logic [USAGE_W-1:0] u5);
      report_type r;
      r.action    = ACTION_REPORT;
      r.modifiers = mods;
      r.usage[0]  = u0;
      r.usage[1]  = u1;
      r.usage[2]  = u2;
      r.usage[3]  = u3;
      r.usage[4]  = u4;
      r.usage[5]  = u5;
      return r;
   endfunction

   // mostly a keyboard being typed on: up to two slots change per report
   function automatic report_type random_report();
      report_type r;
      int      sel;
      int      changes;
      int      slot;
      int      other;
      logic [USAGE_W-1:0] tmp;
      sel = $urandom_range(99);
      if (sel < 15) begin
         r.action    = (sel < 5) ? ACTION_DISCONNECT : ACTION_REPORT;
         r.modifiers = MOD_W'($urandom());
         for (int i = 0; i < N_USAGE; i++) r.usage[i] = USAGE_W'($urandom());
         return r;
      end
      changes = $urandom_range(2);
      repeat (changes) begin
         slot = $urandom_range(N_USAGE - 1);
         case ($urandom_range(9))
            0, 1:    typed[slot] = '0;
            2:       typed[slot] = USAGE_BACKSPACE;
            3:       typed[slot] = USAGE_W'($urandom_range(USAGE_ENTER, USAGE_SPACE));
            default: typed[slot] = USAGE_W'($urandom_range(USAGE_A, USAGE_0));
         endcase
      end
      // reorder now and then so arrival order differs from slot order
      if ($urandom_range(7) == 0) begin
         slot        = $urandom_range(N_USAGE - 1);
         other       = $urandom_range(N_USAGE - 1);
         tmp         = typed[slot];
         typed[slot] = typed[other];
         typed[other] = tmp;
      end
      r.action = ACTION_REPORT;
      if ($urandom_range(3) == 0)
         r.modifiers = MOD_W'($urandom());
      else
         r.modifiers = MOD_W'($urandom_range(3) << MOD_SHIFT_BIT);
      for (int i = 0; i < N_USAGE; i++) r.usage[i] = typed[i];
      return r;
   endfunction

   // ------------------------------------------------------------------ tests

   task automatic test_key_map_and_modifiers();
      send_report(keyboard_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(keyboard_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_report(keyboard_report(8'h02, USAGE_A, USAGE_Z, USAGE_1, USAGE_9, USAGE_0,
                                  USAGE_ENTER));
      // duplicate Z and unmapped usages below the letters
      send_report(keyboard_report(8'h04, USAGE_SPACE, USAGE_Z, USAGE_Z, 8'h01, 8'h03,
                                  USAGE_A));
      // only non-shift, non-alt modifier bits; all usages unmapped
      send_report(keyboard_report(8'hF9, 8'h29, 8'h2B, 8'h2D, 8'h39, 8'hE1, 8'h00));
      send_report(keyboard_report(8'h06, 8'h05, 8'h1C, 8'h1F, 8'h25, 8'h80, 8'h7F));
      send_report(keyboard_report(8'h06, 8'h05, 8'h1C, 8'h1F, 8'h25, 8'h80, 8'h7F));
      send_report(keyboard_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   task automatic test_backspace_and_disconnect();
      report_type r;
      send_report(keyboard_report(8'h00, USAGE_BACKSPACE, USAGE_A, 8'h00, 8'h00, 8'h00,
                                  8'h00));
      // still held: no second delete
      send_report(keyboard_report(8'h00, USAGE_A, USAGE_BACKSPACE, USAGE_0, 8'h00, 8'h00,
                                  8'h00));
      send_report(keyboard_report(8'h02, USAGE_BACKSPACE, USAGE_BACKSPACE, USAGE_1, 8'h00,
                                  8'h00, 8'h00));
      send_report(keyboard_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(keyboard_report(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                  USAGE_BACKSPACE));
      // fullest held list a report can make
      send_report(keyboard_report(8'h00, USAGE_BACKSPACE, USAGE_A, USAGE_Z, USAGE_ENTER,
                                  USAGE_SPACE, USAGE_9));
      r = keyboard_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      r.action = ACTION_DISCONNECT;
      send_report(r);
      // everything re-pressed and delete fires again after a disconnect
      send_report(keyboard_report(8'h00, USAGE_BACKSPACE, USAGE_A, 8'h00, 8'h00, 8'h00,
                                  8'h00));
      r = keyboard_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      r.action = ACTION_DISCONNECT;
      send_report(r);
      send_report(r);
      send_report(keyboard_report(8'h02, USAGE_A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   task automatic test_random_typing(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) wait_until_drained();
         send_report(random_report());
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 47;
      test_key_map_and_modifiers();
      test_backspace_and_disconnect();
      test_random_typing(50);

      send_idle_pct = 47;
      recv_idle_pct = 29;
      test_random_typing(50);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_typing(50);

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("[hid_keyboard_report_to_key_events_core] OK");
      else
         $display("[hid_keyboard_report_to_key_events_core] ERROR");
      $finish;
   end

endmodule
